FILE: hw/rtl/top_k_traffic_tracker_unit_defines.svh
// Assertion macros for the top-k traffic tracker.
`ifndef TOP_K_TRAFFIC_TRACKER_UNIT_DEFINES_SVH
`define TOP_K_TRAFFIC_TRACKER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TTK_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define TTK_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/ttk_pkg.sv
// Package: types, constants and control structs of the top-k traffic tracker.
package ttk_pkg;

    localparam int LIST_DEPTH_DEF = 64;
    localparam int IP_W           = 32;
    localparam int BYTES_W        = 48;
    localparam int TOTAL_W        = 49;
    localparam int RANK_W         = 6;

    typedef struct packed {
        logic [IP_W-1:0]    source_ip;
        logic [BYTES_W-1:0] in_bytes;
        logic [BYTES_W-1:0] out_bytes;
        logic               end_of_set;
    } in_item_t;

    typedef struct packed {
        logic [RANK_W-1:0]  rank;
        logic [IP_W-1:0]    entry_ip;
        logic [TOTAL_W-1:0] total_bytes;
        logic               final_entry;
    } out_item_t;

    typedef enum logic [0:0] {
        ST_COLLECT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic insert;
        logic load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic last_entry;
    } dp_status_t;

endpackage

FILE: hw/rtl/ttk_ctrl.sv
// Controller: collect/emit state machine and output valid flag.
module ttk_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_last,
    output logic                in_ready,
    input  logic                out_ready,
    output logic                out_valid,
    input  ttk_pkg::dp_status_t sts,
    output ttk_pkg::ctrl_cmd_t  cmd
);

    ttk_pkg::state_t state_reg;
    ttk_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ttk_pkg::ST_COLLECT:
            begin
                if (cmd.insert && in_last)
                begin
                    state_next = ttk_pkg::ST_EMIT;
                end
            end
            ttk_pkg::ST_EMIT:
            begin
                if (cmd.load && sts.last_entry)
                begin
                    state_next = ttk_pkg::ST_COLLECT;
                end
            end
            default:
            begin
                state_next = ttk_pkg::ST_COLLECT;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        cmd.insert = 1'b0;
        cmd.load   = 1'b0;
        case (state_reg)
            ttk_pkg::ST_COLLECT:
            begin
                in_ready   = 1'b1;
                cmd.insert = in_valid;
            end
            ttk_pkg::ST_EMIT:
            begin
                cmd.load = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ttk_pkg::ST_COLLECT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: hw/rtl/ttk_datapath.sv
// Datapath: row of compare-and-shift list cells, entry count and output register.
module ttk_datapath
#(
    parameter int LIST_DEPTH = ttk_pkg::LIST_DEPTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  ttk_pkg::in_item_t   in_data,
    input  ttk_pkg::ctrl_cmd_t  cmd,
    output ttk_pkg::dp_status_t sts,
    output ttk_pkg::out_item_t  out_data
);

    localparam int CNT_W = $clog2(LIST_DEPTH + 1);

    logic [ttk_pkg::IP_W-1:0]    ip_reg     [LIST_DEPTH];
    logic [ttk_pkg::IP_W-1:0]    ip_next    [LIST_DEPTH];
    logic [ttk_pkg::TOTAL_W-1:0] total_reg  [LIST_DEPTH];
    logic [ttk_pkg::TOTAL_W-1:0] total_next [LIST_DEPTH];
    logic [LIST_DEPTH-1:0]       greater;
    logic [ttk_pkg::TOTAL_W-1:0] new_total;
    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            count_next;
    logic [ttk_pkg::RANK_W-1:0]  rank_reg;
    logic [ttk_pkg::RANK_W-1:0]  rank_next;
    logic                        full;
    logic                        last_entry;
    ttk_pkg::out_item_t          out_data_reg;

    assign new_total  = {1'b0, in_data.in_bytes} + {1'b0, in_data.out_bytes};
    assign full       = (count_reg == CNT_W'(LIST_DEPTH));
    assign last_entry = (count_reg == CNT_W'(1));
    assign sts.last_entry = last_entry;

    // Occupied cells holding a strictly larger total form a prefix of the list.
    always_comb
    begin
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            greater[i] = (CNT_W'(i) < count_reg) && (total_reg[i] > new_total);
        end
    end

    always_comb
    begin
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            ip_next[i]    = ip_reg[i];
            total_next[i] = total_reg[i];
            if (cmd.insert)
            begin
                if (!greater[i])
                begin
                    if (i == 0)
                    begin
                        ip_next[i]    = in_data.source_ip;
                        total_next[i] = new_total;
                    end
                    else if (greater[i-1])
                    begin
                        ip_next[i]    = in_data.source_ip;
                        total_next[i] = new_total;
                    end
                    else
                    begin
                        ip_next[i]    = ip_reg[i-1];
                        total_next[i] = total_reg[i-1];
                    end
                end
            end
            else if (cmd.load && (i < LIST_DEPTH - 1))
            begin
                ip_next[i]    = ip_reg[i+1];
                total_next[i] = total_reg[i+1];
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        rank_next  = rank_reg;
        if (cmd.insert && !full)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.load)
        begin
            count_next = count_reg - CNT_W'(1);
            rank_next  = last_entry ? '0 : rank_reg + ttk_pkg::RANK_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            ip_reg[i]    <= ip_next[i];
            total_reg[i] <= total_next[i];
        end
        if (cmd.load)
        begin
            out_data_reg.rank        <= rank_reg;
            out_data_reg.entry_ip    <= ip_reg[0];
            out_data_reg.total_bytes <= total_reg[0];
            out_data_reg.final_entry <= last_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            rank_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            rank_reg  <= rank_next;
        end
    end

    assign out_data = out_data_reg;

endmodule

FILE: hw/rtl/top_k_traffic_tracker_unit.sv
// Top-K traffic tracker: keeps the LIST_DEPTH heaviest sources of a set, in
// descending order of in_bytes + out_bytes, and emits them when the set ends.
// While a set is being collected one transaction is taken every cycle: a row
// of compare-and-shift cells places the new entry directly below all entries
// with a strictly larger total (ties go above older equal entries; on a full
// list the bottom entry drops, or the new one if the bottom one is larger).
// After the transaction marked end_of_set is inserted, the list drains at one
// result per cycle unless out_ready holds it off, rank 0 first, by shifting
// the cell row up; input is held off while the list drains, including any
// output stalls. The last result has final_entry set and the list is then empty.
`include "top_k_traffic_tracker_unit_defines.svh"

module top_k_traffic_tracker_unit
#(
    parameter int LIST_DEPTH = ttk_pkg::LIST_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ttk_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output ttk_pkg::out_item_t out_data
);

    ttk_pkg::ctrl_cmd_t  cmd;
    ttk_pkg::dp_status_t sts;

    ttk_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_last   (in_data.end_of_set),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .sts       (sts),
        .cmd       (cmd)
    );

    ttk_datapath
    #(
        .LIST_DEPTH (LIST_DEPTH)
    )
    u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .sts      (sts),
        .out_data (out_data)
    );

    `TTK_ASSERT_NXT(a_emit_after_set_end, in_valid && in_ready && in_data.end_of_set, !in_ready, "input taken right after end of set")
    `TTK_ASSERT_IMP(a_no_input_mid_drain, out_valid && out_ready && !out_data.final_entry, !in_ready, "input open while list still draining")

endmodule
